// ===== rtl/fdc_pkg.sv =====
// Shared constants, types and command codes for the frame deframer and channel decoder.
// Depends on nothing; every other file in rtl imports it.
package fdc_pkg;

    localparam int FRAME_DEPTH = 32;
    localparam int FD_AW       = $clog2(FRAME_DEPTH);

    localparam logic [7:0] SOF_BYTE   = 8'h7E;
    localparam logic [7:0] ESC_BYTE   = 8'h7D;
    localparam logic [7:0] ESC_ADD    = 8'h20;
    localparam logic [7:0] TYPE_CHAN  = 8'h00;
    localparam logic [7:0] TYPE_TELE  = 8'h01;

    localparam int CH_FIRST_POS = 3;
    localparam int FLAG_POS     = 25;
    localparam int RSSI_POS     = 26;
    localparam int CH_BITS      = 11;
    localparam int LAST_CH      = 15;
    localparam int FLAG_LOST    = 2;
    localparam int FLAG_FS      = 3;

    localparam int QDEPTH = 2;

    typedef enum logic [1:0] {
        ST_ERR  = 2'd0,
        ST_CHAN = 2'd1,
        ST_TELE = 2'd2,
        ST_DATA = 2'd3
    } t_status;

    typedef struct packed {
        logic             en;
        logic [FD_AW-1:0] addr;
    } t_rd_req;

endpackage

// ===== rtl/fdc_front.sv =====
// Front end: byte hunting, unescaping, checksum, frame store and command issue.
// Depends on fdc_pkg; feeds fdc_queue and serves store reads to fdc_back.
module fdc_front import fdc_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_rx_valid,
    output logic       o_rx_ready,
    input  logic [7:0] i_rx_byte,
    output logic       o_push,
    output t_status    o_push_cmd,
    input  logic       i_q_full,
    input  logic       i_chan_done,
    input  t_rd_req    i_rd,
    output logic [7:0] o_rd_data
);

    typedef enum logic [4:0] {
        PH_HUNT = 5'b00001,
        PH_LEN  = 5'b00010,
        PH_PAY  = 5'b00100,
        PH_SUM  = 5'b01000,
        PH_END  = 5'b10000
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [7:0]  r_wr_off, n_wr_off;
    logic [7:0]  r_len, n_len;
    logic [15:0] r_sum, n_sum;
    logic        r_esc, n_esc;
    logic [7:0]  r_type, n_type;
    logic        r_chan_pend, n_chan_pend;
    logic [7:0]  r_store [FRAME_DEPTH];
    logic [7:0]  r_rd_data;

    logic             w_acc;
    logic [7:0]       w_pay;
    logic [8:0]       w_pos;
    logic             w_pos_ok;
    logic [7:0]       w_off_inc;
    logic [8:0]       w_f1;
    logic [7:0]       w_f2;
    logic [7:0]       w_chk;
    logic             w_we;
    logic [FD_AW-1:0] w_waddr;
    logic [7:0]       w_wdata;

    assign o_rx_ready = !i_q_full && !r_chan_pend;
    assign w_acc      = i_rx_valid && o_rx_ready;
    assign w_pay      = r_esc ? (i_rx_byte + ESC_ADD) : i_rx_byte;
    assign w_pos      = 9'd2 + {1'b0, r_wr_off};
    assign w_pos_ok   = w_pos < 9'(FRAME_DEPTH);
    assign w_off_inc  = r_wr_off + 8'd1;
    assign w_f1       = {1'b0, r_sum[7:0]} + {1'b0, r_sum[15:8]};
    assign w_f2       = w_f1[7:0] + {7'd0, w_f1[8]};
    assign w_chk      = ~w_f2;
    assign o_rd_data  = r_rd_data;

    always_comb begin
        n_phase     = r_phase;
        n_wr_off    = r_wr_off;
        n_len       = r_len;
        n_sum       = r_sum;
        n_esc       = r_esc;
        n_type      = r_type;
        w_we        = 1'b0;
        w_waddr     = '0;
        w_wdata     = i_rx_byte;
        o_push      = 1'b0;
        o_push_cmd  = ST_ERR;
        if (w_acc) begin
            unique case (r_phase)
                PH_LEN: begin
                    if (i_rx_byte == SOF_BYTE) begin
                        w_we = 1'b1;
                    end else begin
                        n_len    = i_rx_byte;
                        w_we     = 1'b1;
                        w_waddr  = FD_AW'(1);
                        n_sum    = {8'd0, i_rx_byte};
                        n_wr_off = '0;
                        n_esc    = 1'b0;
                        n_phase  = PH_PAY;
                    end
                end
                PH_PAY: begin
                    if (!r_esc && i_rx_byte == ESC_BYTE) begin
                        n_esc = 1'b1;
                    end else begin
                        n_esc    = 1'b0;
                        w_we     = w_pos_ok;
                        w_waddr  = w_pos[FD_AW-1:0];
                        w_wdata  = w_pay;
                        n_sum    = r_sum + {8'd0, w_pay};
                        n_wr_off = w_off_inc;
                        if (r_wr_off == 8'd0) begin
                            n_type = w_pay;
                        end
                        if (w_off_inc >= r_len) begin
                            n_phase = PH_SUM;
                        end
                    end
                end
                PH_SUM: begin
                    if (w_chk == i_rx_byte) begin
                        n_phase = PH_END;
                    end else begin
                        n_phase    = PH_HUNT;
                        o_push     = 1'b1;
                        o_push_cmd = ST_ERR;
                    end
                end
                PH_END: begin
                    n_phase = PH_HUNT;
                    o_push  = 1'b1;
                    if (i_rx_byte != SOF_BYTE) begin
                        o_push_cmd = ST_ERR;
                    end else if (r_type == TYPE_TELE) begin
                        o_push_cmd = ST_TELE;
                    end else if (r_type == TYPE_CHAN) begin
                        o_push_cmd = ST_CHAN;
                    end else begin
                        o_push_cmd = ST_DATA;
                    end
                end
                default: begin
                    n_phase = PH_HUNT;
                    if (i_rx_byte == SOF_BYTE) begin
                        w_we     = 1'b1;
                        n_phase  = PH_LEN;
                        n_wr_off = '0;
                    end
                end
            endcase
        end
    end

    always_comb begin
        n_chan_pend = r_chan_pend;
        if (o_push && o_push_cmd == ST_CHAN) begin
            n_chan_pend = 1'b1;
        end else if (i_chan_done) begin
            n_chan_pend = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_wr_off    <= '0;
            r_len       <= '0;
            r_sum       <= '0;
            r_esc       <= 1'b0;
            r_chan_pend <= 1'b0;
        end else begin
            r_phase     <= n_phase;
            r_wr_off    <= n_wr_off;
            r_len       <= n_len;
            r_sum       <= n_sum;
            r_esc       <= n_esc;
            r_chan_pend <= n_chan_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_type <= n_type;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_store[w_waddr] <= w_wdata;
        end
        if (i_rd.en) begin
            r_rd_data <= r_store[i_rd.addr];
        end
    end

endmodule

// ===== rtl/fdc_queue.sv =====
// Short command queue between the front end and the result sequencer.
// Depends on fdc_pkg for the command type and depth.
module fdc_queue import fdc_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_status i_push_cmd,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_empty,
    output t_status o_head
);

    localparam int Q_AW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int Q_CW = $clog2(QDEPTH + 1);

    t_status          r_slot [QDEPTH];
    logic [Q_AW-1:0]  r_wp, r_rp;
    logic [Q_CW-1:0]  r_count;

    assign o_full  = r_count == Q_CW'(QDEPTH);
    assign o_empty = r_count == '0;
    assign o_head  = r_slot[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == Q_AW'(QDEPTH - 1)) ? '0 : r_wp + Q_AW'(1);
            end
            if (i_pop) begin
                r_rp <= (r_rp == Q_AW'(QDEPTH - 1)) ? '0 : r_rp + Q_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wp] <= i_push_cmd;
        end
    end

endmodule

// ===== rtl/fdc_back.sv =====
// Result sequencer: turns queued commands into result items and unpacks channels
// by streaming store bytes through a bit accumulator. Depends on fdc_pkg.
module fdc_back import fdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_status     i_q_head,
    output logic        o_pop,
    output t_rd_req     o_rd,
    input  logic [7:0]  i_rd_data,
    output logic        o_chan_done,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_channel_index,
    output logic [10:0] o_channel_value,
    output logic        o_frame_lost,
    output logic        o_failsafe,
    output logic [7:0]  o_rssi,
    output logic        o_last
);

    typedef enum logic [7:0] {
        B_IDLE     = 8'b00000001,
        B_RD       = 8'b00000010,
        B_ABS      = 8'b00000100,
        B_EMIT     = 8'b00001000,
        B_FLAG_RD  = 8'b00010000,
        B_FLAG_ABS = 8'b00100000,
        B_RSSI_ABS = 8'b01000000,
        B_LAST     = 8'b10000000
    } t_bstate;

    t_bstate          r_state, n_state;
    logic [FD_AW-1:0] r_addr, n_addr;
    logic [17:0]      r_acc, n_acc;
    logic [4:0]       r_cnt, n_cnt;
    logic [3:0]       r_ch, n_ch;
    logic             r_lost, n_lost;
    logic             r_fs, n_fs;
    logic [7:0]       r_rssi, n_rssi;

    logic             r_out_valid;
    t_status          r_status;
    logic [3:0]       r_idx;
    logic [10:0]      r_val;
    logic             r_lost_o, r_fs_o, r_last;
    logic [7:0]       r_rssi_o;

    logic             w_slot;
    logic             w_load;
    t_status          w_ld_status;
    logic [3:0]       w_ld_idx;
    logic [10:0]      w_ld_val;
    logic             w_ld_lost, w_ld_fs, w_ld_last;
    logic [7:0]       w_ld_rssi;

    assign w_slot = !r_out_valid || i_res_ready;

    always_comb begin
        n_state     = r_state;
        n_addr      = r_addr;
        n_acc       = r_acc;
        n_cnt       = r_cnt;
        n_ch        = r_ch;
        n_lost      = r_lost;
        n_fs        = r_fs;
        n_rssi      = r_rssi;
        o_pop       = 1'b0;
        o_rd        = '0;
        o_chan_done = 1'b0;
        w_load      = 1'b0;
        w_ld_status = ST_ERR;
        w_ld_idx    = '0;
        w_ld_val    = '0;
        w_ld_lost   = 1'b0;
        w_ld_fs     = 1'b0;
        w_ld_rssi   = '0;
        w_ld_last   = 1'b0;
        unique case (r_state)
            B_IDLE: begin
                if (!i_q_empty) begin
                    if (i_q_head == ST_CHAN) begin
                        o_pop   = 1'b1;
                        n_addr  = FD_AW'(CH_FIRST_POS);
                        n_acc   = '0;
                        n_cnt   = '0;
                        n_ch    = '0;
                        n_state = B_RD;
                    end else if (w_slot) begin
                        o_pop       = 1'b1;
                        w_load      = 1'b1;
                        w_ld_status = i_q_head;
                        w_ld_last   = 1'b1;
                    end
                end
            end
            B_RD: begin
                o_rd.en   = 1'b1;
                o_rd.addr = r_addr;
                n_state   = B_ABS;
            end
            B_ABS: begin
                n_acc   = r_acc | ({10'd0, i_rd_data} << r_cnt);
                n_cnt   = r_cnt + 5'd8;
                n_addr  = r_addr + FD_AW'(1);
                n_state = (n_cnt >= 5'(CH_BITS)) ? B_EMIT : B_RD;
            end
            B_EMIT: begin
                if (r_ch == 4'(LAST_CH)) begin
                    n_state = B_FLAG_RD;
                end else if (w_slot) begin
                    w_load      = 1'b1;
                    w_ld_status = ST_CHAN;
                    w_ld_idx    = r_ch;
                    w_ld_val    = r_acc[10:0];
                    n_acc       = r_acc >> CH_BITS;
                    n_cnt       = r_cnt - 5'(CH_BITS);
                    n_ch        = r_ch + 4'd1;
                    n_state     = B_RD;
                end
            end
            B_FLAG_RD: begin
                o_rd.en   = 1'b1;
                o_rd.addr = FD_AW'(FLAG_POS);
                n_state   = B_FLAG_ABS;
            end
            B_FLAG_ABS: begin
                n_lost    = i_rd_data[FLAG_LOST];
                n_fs      = i_rd_data[FLAG_FS];
                o_rd.en   = 1'b1;
                o_rd.addr = FD_AW'(RSSI_POS);
                n_state   = B_RSSI_ABS;
            end
            B_RSSI_ABS: begin
                n_rssi  = i_rd_data;
                n_state = B_LAST;
            end
            B_LAST: begin
                if (w_slot) begin
                    w_load      = 1'b1;
                    w_ld_status = ST_CHAN;
                    w_ld_idx    = r_ch;
                    w_ld_val    = r_acc[10:0];
                    w_ld_lost   = r_lost;
                    w_ld_fs     = r_fs;
                    w_ld_rssi   = r_rssi;
                    w_ld_last   = 1'b1;
                    o_chan_done = 1'b1;
                    n_state     = B_IDLE;
                end
            end
            default: begin
                n_state = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= B_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_acc  <= n_acc;
        r_cnt  <= n_cnt;
        r_ch   <= n_ch;
        r_lost <= n_lost;
        r_fs   <= n_fs;
        r_rssi <= n_rssi;
        if (w_load) begin
            r_status <= w_ld_status;
            r_idx    <= w_ld_idx;
            r_val    <= w_ld_val;
            r_lost_o <= w_ld_lost;
            r_fs_o   <= w_ld_fs;
            r_rssi_o <= w_ld_rssi;
            r_last   <= w_ld_last;
        end
    end

    assign o_res_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_channel_index = r_idx;
    assign o_channel_value = r_val;
    assign o_frame_lost    = r_lost_o;
    assign o_failsafe      = r_fs_o;
    assign o_rssi          = r_rssi_o;
    assign o_last          = r_last;

endmodule

// ===== rtl/fport_deframer_channel_decoder.sv =====
// Top level of the frame deframer and channel decoder.
// Depends on fdc_pkg, fdc_front, fdc_queue and fdc_back.
//
//   Channel   Direction  Handshake                  Payload
//   rx        in         i_rx_valid / o_rx_ready    i_rx_byte
//   result    out        o_res_valid / i_res_ready  o_status .. o_last
//
// The front end is ready while the queue has room and no channel frame is being unpacked.
// A good channel frame holds the input for the unpack burst: 22 store reads, 16 channel results
// and the reads of the flag and RSSI bytes, plus any output stalls.
// Reset is synchronous; the frame store is not cleared, so a short frame can read stale bytes.
// A full output register with i_res_ready low stalls the sequencer, which in turn fills the queue.
module fport_deframer_channel_decoder import fdc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    output logic        o_rx_ready,
    input  logic [7:0]  i_rx_byte,
    output logic        o_res_valid,
    input  logic        i_res_ready,
    output logic [1:0]  o_status,
    output logic [3:0]  o_channel_index,
    output logic [10:0] o_channel_value,
    output logic        o_frame_lost,
    output logic        o_failsafe,
    output logic [7:0]  o_rssi,
    output logic        o_last
);

    logic       w_push;
    t_status    w_push_cmd;
    logic       w_pop;
    logic       w_q_full;
    logic       w_q_empty;
    t_status    w_q_head;
    logic       w_chan_done;
    t_rd_req    w_rd;
    logic [7:0] w_rd_data;

    fdc_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_byte   (i_rx_byte),
        .o_push      (w_push),
        .o_push_cmd  (w_push_cmd),
        .i_q_full    (w_q_full),
        .i_chan_done (w_chan_done),
        .i_rd        (w_rd),
        .o_rd_data   (w_rd_data)
    );

    fdc_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_push_cmd (w_push_cmd),
        .i_pop      (w_pop),
        .o_full     (w_q_full),
        .o_empty    (w_q_empty),
        .o_head     (w_q_head)
    );

    fdc_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (w_q_empty),
        .i_q_head        (w_q_head),
        .o_pop           (w_pop),
        .o_rd            (w_rd),
        .i_rd_data       (w_rd_data),
        .o_chan_done     (w_chan_done),
        .o_res_valid     (o_res_valid),
        .i_res_ready     (i_res_ready),
        .o_status        (o_status),
        .o_channel_index (o_channel_index),
        .o_channel_value (o_channel_value),
        .o_frame_lost    (o_frame_lost),
        .o_failsafe      (o_failsafe),
        .o_rssi          (o_rssi),
        .o_last          (o_last)
    );

`ifndef SYNTHESIS
    a_single_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status != ST_CHAN) |-> o_last)
        else $error("Non-channel result without last.");

    a_last_channel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_valid && o_status == ST_CHAN && o_last) |-> (o_channel_index == 4'(LAST_CH)))
        else $error("Channel burst ended on the wrong channel.");

    a_done_shows_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_chan_done |=> (o_res_valid && o_last && o_channel_index == 4'(LAST_CH)))
        else $error("Burst completion did not present the final channel.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_empty)
        else $error("Command queue popped while empty.");
`endif

endmodule
